>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros used by the edge detector's result sequencer, sobel_emit
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge out of reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/sobel_pkg.sv
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared widths, register indexes, result kinds and the word passed from the
// gradient stage to the result sequencer.
// ----------------------------------------------------------------------------
package sobel_pkg;

    // frame geometry limits
    localparam int MAX_COLS  = 1024;
    localparam int MAX_ROWS  = 1024;
    localparam int COL_W     = 10;
    localparam int ROW_W     = 10;
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 11;
    localparam int THR_W     = 9;
    localparam int CNT_W     = 21;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 2'd2;

    // register values after reset
    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH    = 11'd640;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT   = 11'd480;
    localparam logic [THR_W-1:0] RST_EDGE_THRESHOLD = 9'd120;

    localparam logic [CFG_W-1:0] SIZE_MIN = 11'd3;
    localparam logic [CFG_W-1:0] COLS_MAX = CFG_W'(MAX_COLS);
    localparam logic [CFG_W-1:0] ROWS_MAX = CFG_W'(MAX_ROWS);

    // result kinds an input pixel can cause, in emission order
    localparam int KIND_MAIN     = 0;  // pixel one behind, or row 0 pixel
    localparam int KIND_ROW_END  = 1;  // right border pixel of the row above
    localparam int KIND_LAST_ROW = 2;  // bottom border pixel
    localparam int NUM_KINDS     = 3;

    typedef logic [NUM_KINDS-1:0] t_kind_mask;

    // one input pixel's worth of pending results
    typedef struct packed {
        logic [PIX_W-1:0] mag;       // clamped magnitude for the main result
        logic [COL_W-1:0] col_main;  // column of the main result
        logic [ROW_W-1:0] row_up;    // row of main and row-end results
        logic [COL_W-1:0] col;       // column of the input pixel
        logic [ROW_W-1:0] row;       // row of the input pixel
        t_kind_mask       mask;      // which results this pixel causes
        logic             new_frame; // counters restarted on this pixel
        logic             frame_end; // last pixel of the frame
    } t_item;

    // frame size clamped into the supported range
    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                    input logic [CFG_W-1:0] lim);
        logic [CFG_W-1:0] res;
        res = v;
        if (v < SIZE_MIN) begin
            res = SIZE_MIN;
        end else if (v > lim) begin
            res = lim;
        end
        return res;
    endfunction

endpackage

>>> hdl/sobel_linebuf.sv
// ----------------------------------------------------------------------------
// sobel_linebuf
// Two row memories holding the previous two rows, registered read and a
// write-back that rotates the column: upper takes middle, middle takes pixel.
// ----------------------------------------------------------------------------
module sobel_linebuf
    import sobel_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [COL_W-1:0] i_rd_addr,
    input  logic             i_wr_en,
    input  logic [COL_W-1:0] i_wr_addr,
    input  logic [PIX_W-1:0] i_wr_px,
    output logic [PIX_W-1:0] o_top,
    output logic [PIX_W-1:0] o_mid
);

    logic [PIX_W-1:0] r_upper [MAX_COLS];
    logic [PIX_W-1:0] r_middle [MAX_COLS];
    logic [PIX_W-1:0] r_top;
    logic [PIX_W-1:0] r_mid;

    // registered reads of both rows at the accepted column
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_top <= r_upper[i_rd_addr];
            r_mid <= r_middle[i_rd_addr];
        end
    end

    // column write-back once the word leaves the read stage
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_upper[i_wr_addr]  <= r_mid;
            r_middle[i_wr_addr] <= i_wr_px;
        end
    end

    assign o_top = r_top;
    assign o_mid = r_mid;

endmodule

>>> hdl/sobel_window.sv
// ----------------------------------------------------------------------------
// sobel_window
// Six window registers for the two left columns of the 3x3 neighborhood and
// the |Gx|+|Gy| magnitude, clamped to 8 bits.
// ----------------------------------------------------------------------------
module sobel_window
    import sobel_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  logic [PIX_W-1:0] i_top,
    input  logic [PIX_W-1:0] i_mid,
    input  logic [PIX_W-1:0] i_px,
    output logic [PIX_W-1:0] o_mag
);

    // 0..2: left column top..bottom, 3..5: centre column top..bottom
    logic [PIX_W-1:0] r_win [6];

    logic [PIX_W+1:0] gx_pos;
    logic [PIX_W+1:0] gx_neg;
    logic [PIX_W+1:0] gy_pos;
    logic [PIX_W+1:0] gy_neg;
    logic [PIX_W+1:0] abs_x;
    logic [PIX_W+1:0] abs_y;
    logic [PIX_W+2:0] mag_sum;

    // shift the window left by one column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_shift) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= i_top;
            r_win[4] <= i_mid;
            r_win[5] <= i_px;
        end
    end

    // kernel sums, right minus left and bottom minus top
    always_comb begin
        gx_pos = {2'b00, i_top} + {1'b0, i_mid, 1'b0} + {2'b00, i_px};
        gx_neg = {2'b00, r_win[0]} + {1'b0, r_win[1], 1'b0} + {2'b00, r_win[2]};
        gy_pos = {2'b00, r_win[2]} + {1'b0, r_win[5], 1'b0} + {2'b00, i_px};
        gy_neg = {2'b00, r_win[0]} + {1'b0, r_win[3], 1'b0} + {2'b00, i_top};
        abs_x  = (gx_pos >= gx_neg) ? (gx_pos - gx_neg) : (gx_neg - gx_pos);
        abs_y  = (gy_pos >= gy_neg) ? (gy_pos - gy_neg) : (gy_neg - gy_pos);
        mag_sum = {1'b0, abs_x} + {1'b0, abs_y};
    end

    // saturate to 255
    assign o_mag = (|mag_sum[PIX_W+2:PIX_W]) ? {PIX_W{1'b1}} : mag_sum[PIX_W-1:0];

endmodule

>>> hdl/sobel_emit.sv
// ----------------------------------------------------------------------------
// sobel_emit
// Holds one pixel's pending results, sends them one word per cycle into the
// output register if free, thresholds them and keeps the frame's edge count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sobel_emit
    import sobel_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [THR_W-1:0] i_threshold,
    input  logic             i_valid,
    input  t_item            i_item,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [PIX_W-1:0] o_out_value,
    output logic [COL_W-1:0] o_out_col,
    output logic [ROW_W-1:0] o_out_row,
    output logic [CNT_W-1:0] o_edge_count,
    output logic             o_last_of_item,
    output logic             o_frame_done
);

    logic             r_b_valid;
    t_item            r_b;
    t_kind_mask       r_pend;
    logic             r_first;
    logic [CNT_W-1:0] r_edge;

    logic             r_o_valid;
    logic [PIX_W-1:0] r_o_value;
    logic [COL_W-1:0] r_o_col;
    logic [ROW_W-1:0] r_o_row;
    logic [CNT_W-1:0] r_o_count;
    logic             r_o_last;
    logic             r_o_fdone;

    logic             out_free;
    logic             load;
    logic             b_done;
    t_kind_mask       rem;
    logic [PIX_W-1:0] sel_mag;
    logic [COL_W-1:0] sel_col;
    logic [ROW_W-1:0] sel_row;
    logic             inc;
    logic [PIX_W-1:0] thr_val;
    logic [CNT_W-1:0] base;
    logic [CNT_W-1:0] n_count;
    logic             fdone;

    // pick the earliest pending result
    always_comb begin
        out_free = !r_o_valid || i_ready;
        load     = r_b_valid && (r_pend != '0) && out_free;
        rem      = r_pend & (r_pend - t_kind_mask'(1));
        b_done   = r_b_valid && ((r_pend == '0) || (load && (rem == '0)));
        if (r_pend[KIND_MAIN]) begin
            sel_mag = r_b.mag;
            sel_col = r_b.col_main;
            sel_row = r_b.row_up;
        end else if (r_pend[KIND_ROW_END]) begin
            sel_mag = '0;
            sel_col = r_b.col;
            sel_row = r_b.row_up;
        end else begin
            sel_mag = '0;
            sel_col = r_b.col;
            sel_row = r_b.row;
        end
    end

    // threshold and running edge count
    always_comb begin
        inc     = {1'b0, sel_mag} >= i_threshold;
        thr_val = inc ? sel_mag : '0;
        base    = (r_first && r_b.new_frame) ? '0 : r_edge;
        n_count = base + CNT_W'(inc);
        fdone   = (rem == '0) && r_b.frame_end;
    end

    assign o_ready = !r_b_valid || b_done;

    // pixel holding stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_pend    <= '0;
            r_first   <= 1'b0;
        end else if (o_ready) begin
            r_b_valid <= i_valid;
            r_pend    <= i_valid ? i_item.mask : '0;
            r_first   <= 1'b1;
        end else if (load) begin
            r_pend  <= rem;
            r_first <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_b <= i_item;
        end
    end

    // edge counter, cleared on a restart and after the frame's last word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge <= '0;
        end else if (load) begin
            r_edge <= fdone ? '0 : n_count;
        end else if (b_done && r_first && r_b.new_frame) begin
            r_edge <= '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_value <= ~thr_val;
            r_o_col   <= sel_col;
            r_o_row   <= sel_row;
            r_o_count <= n_count;
            r_o_last  <= (rem == '0);
            r_o_fdone <= fdone;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_out_value    = r_o_value;
    assign o_out_col      = r_o_col;
    assign o_out_row      = r_o_row;
    assign o_edge_count   = r_o_count;
    assign o_last_of_item = r_o_last;
    assign o_frame_done   = r_o_fdone;

    // checks
    `ASSERT_IMPLY(a_pend_needs_item, i_clk, i_rst_n, r_pend != '0, r_b_valid, "pending results without a held pixel")
    `ASSERT_IMPLY(a_fdone_is_last, i_clk, i_rst_n, r_o_valid && r_o_fdone, r_o_last, "frame end not on last word of pixel")
    `ASSERT_NEXT(a_count_cleared, i_clk, i_rst_n, load && fdone, r_edge == '0, "edge count not cleared at frame end")

endmodule

>>> hdl/sobel_edge_threshold.sv
// ----------------------------------------------------------------------------
// sobel_edge_threshold
// Streaming 3x3 Sobel edge detector with threshold, edge count and position
// tags on every output pixel.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------
//   pixel in | i_valid / o_ready      | i_pixel
//   result   | o_valid / i_ready      | o_out_value .. o_frame_done
//   config   | i_cfg_we (no wait)     | i_cfg_idx, i_cfg_data
//
// One pixel is taken per cycle while each pixel causes at most one word and
// the output is not stalled; a pixel causing two or three words holds the input
// while the result sequencer sends one word per cycle.
// A pixel goes through the read and holding stages into the output register.
// Reset (synchronous, active low) clears counters, window and stage valids;
// the row memories are not cleared.
// A stalled output fills the output register, the holding stage and the read
// stage, then drops o_ready.
// ----------------------------------------------------------------------------
module sobel_edge_threshold
    import sobel_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [PIX_W-1:0]     i_pixel,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [PIX_W-1:0]     o_out_value,
    output logic [COL_W-1:0]     o_out_col,
    output logic [ROW_W-1:0]     o_out_row,
    output logic [CNT_W-1:0]     o_edge_count,
    output logic                 o_last_of_item,
    output logic                 o_frame_done
);

    logic [CFG_W-1:0] r_cfg_width;
    logic [CFG_W-1:0] r_cfg_height;
    logic [THR_W-1:0] r_cfg_thr;

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;

    // read stage, waits for the row memory data
    logic             r_a_valid;
    logic [PIX_W-1:0] r_a_px;
    logic [COL_W-1:0] r_a_c;
    logic [ROW_W-1:0] r_a_r;
    logic             r_a_newfrm;
    logic             r_a_fend;
    logic             r_a_row0;
    logic             r_a_rge2;
    logic             r_a_cend;
    logic             r_a_rlast;

    logic [CFG_W-1:0] w_eff;
    logic [CFG_W-1:0] h_eff;
    logic             newfrm;
    logic [COL_W-1:0] cur_c;
    logic [ROW_W-1:0] cur_r;
    logic [CFG_W-1:0] c_inc;
    logic [CFG_W-1:0] r_inc;
    logic             fend;
    logic             accept;
    logic             a_adv;
    logic             b_ready;
    logic [PIX_W-1:0] top_px;
    logic [PIX_W-1:0] mid_px;
    logic [PIX_W-1:0] grad_mag;
    t_item            item;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RST_IMAGE_WIDTH;
            r_cfg_height <= RST_IMAGE_HEIGHT;
            r_cfg_thr    <= RST_EDGE_THRESHOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_WIDTH:    r_cfg_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT:   r_cfg_height <= i_cfg_data;
                CFG_EDGE_THRESHOLD: r_cfg_thr    <= i_cfg_data[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // position of the arriving pixel and the next position
    always_comb begin
        w_eff  = clamp_size(r_cfg_width, COLS_MAX);
        h_eff  = clamp_size(r_cfg_height, ROWS_MAX);
        newfrm = ({1'b0, r_col} >= w_eff) || ({1'b0, r_row} >= h_eff);
        cur_c  = newfrm ? '0 : r_col;
        cur_r  = newfrm ? '0 : r_row;
        c_inc  = {1'b0, cur_c} + CFG_W'(1);
        r_inc  = {1'b0, cur_r} + CFG_W'(1);
        fend   = 1'b0;
        n_col  = c_inc[COL_W-1:0];
        n_row  = cur_r;
        if (c_inc >= w_eff) begin
            n_col = '0;
            n_row = r_inc[ROW_W-1:0];
            if (r_inc >= h_eff) begin
                n_row = '0;
                fend  = 1'b1;
            end
        end
    end

    // stage handshakes
    assign a_adv   = r_a_valid && b_ready;
    assign o_ready = !r_a_valid || a_adv;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_px     <= i_pixel;
            r_a_c      <= cur_c;
            r_a_r      <= cur_r;
            r_a_newfrm <= newfrm;
            r_a_fend   <= fend;
            r_a_row0   <= (cur_r == '0);
            r_a_rge2   <= (cur_r >= ROW_W'(2));
            r_a_cend   <= ({1'b0, cur_c} == (w_eff - CFG_W'(1)));
            r_a_rlast  <= ({1'b0, cur_r} == (h_eff - CFG_W'(1)));
        end
    end

    sobel_linebuf u_linebuf (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (cur_c),
        .i_wr_en   (a_adv),
        .i_wr_addr (r_a_c),
        .i_wr_px   (r_a_px),
        .o_top     (top_px),
        .o_mid     (mid_px)
    );

    sobel_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (a_adv),
        .i_top   (top_px),
        .i_mid   (mid_px),
        .i_px    (r_a_px),
        .o_mag   (grad_mag)
    );

    // results this pixel causes
    always_comb begin
        item.mag       = (r_a_rge2 && (r_a_c >= COL_W'(2))) ? grad_mag : '0;
        item.col_main  = r_a_row0 ? r_a_c : (r_a_c - COL_W'(1));
        item.row_up    = r_a_row0 ? '0 : (r_a_r - ROW_W'(1));
        item.col       = r_a_c;
        item.row       = r_a_r;
        item.mask[KIND_MAIN]     = r_a_row0 || (r_a_rge2 && (r_a_c != '0));
        item.mask[KIND_ROW_END]  = r_a_rge2 && r_a_cend;
        item.mask[KIND_LAST_ROW] = r_a_rge2 && r_a_rlast;
        item.new_frame = r_a_newfrm;
        item.frame_end = r_a_fend;
    end

    sobel_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_threshold    (r_cfg_thr),
        .i_valid        (r_a_valid),
        .i_item         (item),
        .o_ready        (b_ready),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_value    (o_out_value),
        .o_out_col      (o_out_col),
        .o_out_row      (o_out_row),
        .o_edge_count   (o_edge_count),
        .o_last_of_item (o_last_of_item),
        .o_frame_done   (o_frame_done)
    );

endmodule

>>> tb/sobel_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_stream_checker
// Watches the pixel, result and register channels of the edge detector,
// predicts every result word from the accepted pixels and the register
// writes, and compares each accepted word field by field with the oldest
// prediction. Hands the failure count and the outstanding word count back.
// ----------------------------------------------------------------------------
module sobel_stream_checker
    import sobel_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_pix_valid,
    input  logic                 i_pix_ready,
    input  logic [PIX_W-1:0]     i_pixel,
    input  logic                 i_res_valid,
    input  logic                 i_res_ready,
    input  logic [PIX_W-1:0]     i_out_value,
    input  logic [COL_W-1:0]     i_out_col,
    input  logic [ROW_W-1:0]     i_out_row,
    input  logic [CNT_W-1:0]     i_edge_count,
    input  logic                 i_last_of_item,
    input  logic                 i_frame_done,
    output int                   o_fail_count,
    output int                   o_pending
);

    // one output pixel word
    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [CNT_W-1:0] count;
        logic             last;
        logic             done;
    } t_edge_word;

    t_edge_word       expected_words[$];

    // register copies
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [THR_W-1:0] thresh_reg;

    // row memories and the two held window columns, top to bottom
    logic [PIX_W-1:0] line_two_up[MAX_COLS];
    logic [PIX_W-1:0] line_one_up[MAX_COLS];
    logic [PIX_W-1:0] win_old[3];
    logic [PIX_W-1:0] win_mid[3];

    int               col_pos;
    int               row_pos;
    logic [CNT_W-1:0] edge_cnt;
    int               fail_cnt;
    int               pending_cnt;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pending_cnt;

    // frame size as the block uses it
    function automatic int frame_dim(input logic [CFG_W-1:0] v, input int lim);
        if (v < 3) begin
            return 3;
        end
        if (int'(v) > lim) begin
            return lim;
        end
        return int'(v);
    endfunction

    // threshold one magnitude, bump the edge count and build the word
    function automatic t_edge_word score_pixel(input int mag, input int col, input int row);
        t_edge_word wd;
        int         m;
        m = (mag > 255) ? 255 : mag;
        if (m < int'(thresh_reg)) begin
            m = 0;
        end else begin
            edge_cnt = edge_cnt + 1'b1;
        end
        wd.value = PIX_W'(255 - m);
        wd.col   = COL_W'(col);
        wd.row   = ROW_W'(row);
        wd.count = edge_cnt;
        wd.last  = 1'b0;
        wd.done  = 1'b0;
        return wd;
    endfunction

    // words caused by one accepted pixel
    task automatic sobel_predict(input logic [PIX_W-1:0] px);
        int         w;
        int         h;
        int         c;
        int         r;
        int         gx;
        int         gy;
        int         mag;
        int         n;
        int         k;
        int         lft[3];
        int         ctr[3];
        int         rgt[3];
        logic       frame_end;
        t_edge_word words[3];
        w         = frame_dim(width_reg, MAX_COLS);
        h         = frame_dim(height_reg, MAX_ROWS);
        n         = 0;
        frame_end = 1'b0;

        // position outside a shrunk frame starts a new one
        if (col_pos >= w || row_pos >= h) begin
            col_pos  = 0;
            row_pos  = 0;
            edge_cnt = '0;
        end
        c = col_pos;
        r = row_pos;

        // window shift and row memory update
        for (k = 0; k < 3; k++) begin
            lft[k] = win_old[k];
            ctr[k] = win_mid[k];
        end
        rgt[0] = line_two_up[c];
        rgt[1] = line_one_up[c];
        rgt[2] = px;
        line_two_up[c] = line_one_up[c];
        line_one_up[c] = px;
        win_old = win_mid;
        for (k = 0; k < 3; k++) begin
            win_mid[k] = PIX_W'(rgt[k]);
        end

        if (r == 0) begin
            words[n] = score_pixel(0, c, 0);
            n++;
        end else if (r >= 2) begin
            if (c >= 1) begin
                mag = 0;
                // left border column stays at zero magnitude
                if (c >= 2) begin
                    gx  = (rgt[0] + 2 * rgt[1] + rgt[2]) - (lft[0] + 2 * lft[1] + lft[2]);
                    gy  = (lft[2] + 2 * ctr[2] + rgt[2]) - (lft[0] + 2 * ctr[0] + rgt[0]);
                    mag = ((gx < 0) ? -gx : gx) + ((gy < 0) ? -gy : gy);
                end
                words[n] = score_pixel(mag, c - 1, r - 1);
                n++;
            end
            // right border pixel of the row above
            if (c == w - 1) begin
                words[n] = score_pixel(0, w - 1, r - 1);
                n++;
            end
            // bottom row goes out directly
            if (r == h - 1) begin
                words[n] = score_pixel(0, c, h - 1);
                n++;
            end
        end

        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h) begin
                row_pos   = 0;
                frame_end = 1'b1;
            end
        end

        if (n > 0) begin
            words[n-1].last = 1'b1;
            words[n-1].done = frame_end;
        end
        for (k = 0; k < n; k++) begin
            expected_words.push_back(words[k]);
        end
        if (frame_end) begin
            edge_cnt = '0;
        end
    endtask

    // channel monitor
    always @(posedge i_clk) begin
        t_edge_word got;
        t_edge_word want;
        if (!i_rst_n) begin
            width_reg  = RST_IMAGE_WIDTH;
            height_reg = RST_IMAGE_HEIGHT;
            thresh_reg = RST_EDGE_THRESHOLD;
            for (int k = 0; k < MAX_COLS; k++) begin
                line_two_up[k] = '0;
                line_one_up[k] = '0;
            end
            for (int k = 0; k < 3; k++) begin
                win_old[k] = '0;
                win_mid[k] = '0;
            end
            col_pos  = 0;
            row_pos  = 0;
            edge_cnt = '0;
            fail_cnt = 0;
            expected_words.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IMAGE_WIDTH:    width_reg  = i_cfg_data;
                    CFG_IMAGE_HEIGHT:   height_reg = i_cfg_data;
                    CFG_EDGE_THRESHOLD: thresh_reg = i_cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end

            // accepted pixel
            if (i_pix_valid && i_pix_ready) begin
                sobel_predict(i_pixel);
            end

            // accepted word
            if (i_res_valid && i_res_ready) begin
                got.value = i_out_value;
                got.col   = i_out_col;
                got.row   = i_out_row;
                got.count = i_edge_count;
                got.last  = i_last_of_item;
                got.done  = i_frame_done;
                if (expected_words.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10) begin
                        $display("unexpected word: value %0d col %0d row %0d count %0d",
                                 got.value, got.col, got.row, got.count);
                    end
                end else begin
                    want = expected_words.pop_front();
                    if (got.value !== want.value || got.col !== want.col ||
                        got.row !== want.row || got.count !== want.count ||
                        got.last !== want.last || got.done !== want.done) begin
                        fail_cnt++;
                        if (fail_cnt <= 10) begin
                            $display({"mismatch: exp value %0d col %0d row %0d",
                                      " cnt %0d last %b done %b"},
                                     want.value, want.col, want.row, want.count,
                                     want.last, want.done);
                            $display({"          got value %0d col %0d row %0d",
                                      " cnt %0d last %b done %b"},
                                     got.value, got.col, got.row, got.count,
                                     got.last, got.done);
                        end
                    end
                end
            end
        end
        pending_cnt = expected_words.size();
    end

endmodule

>>> tb/tb_sobel_edge_threshold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sobel_edge_threshold
// Drives pixel frames of many sizes and thresholds into the edge detector:
// a short directed part for the extreme gradients and thresholds, then
// random frames, clamped sizes, mid-frame size changes and both size limits.
// Both channels idle and stall at random; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_sobel_edge_threshold;
    import sobel_pkg::*;

    // no register behind this index
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;

    typedef enum int {
        PIX_RAMP,
        PIX_CHECKER,
        PIX_MIXED
    } t_pix_mode;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_valid;
    logic                 o_ready;
    logic [PIX_W-1:0]     i_pixel;
    logic                 o_valid;
    logic                 i_ready;
    logic [PIX_W-1:0]     o_out_value;
    logic [COL_W-1:0]     o_out_col;
    logic [ROW_W-1:0]     o_out_row;
    logic [CNT_W-1:0]     o_edge_count;
    logic                 o_last_of_item;
    logic                 o_frame_done;

    int                   fail_count;
    int                   pending;
    int                   cycle_cnt;
    int                   rx_stall;
    bit                   rx_burst;
    bit                   tx_burst;
    int                   k;
    int                   fw;
    int                   fh;

    sobel_edge_threshold dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_pixel        (i_pixel),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_value    (o_out_value),
        .o_out_col      (o_out_col),
        .o_out_row      (o_out_row),
        .o_edge_count   (o_edge_count),
        .o_last_of_item (o_last_of_item),
        .o_frame_done   (o_frame_done)
    );

    sobel_stream_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_pix_valid    (i_valid),
        .i_pix_ready    (o_ready),
        .i_pixel        (i_pixel),
        .i_res_valid    (o_valid),
        .i_res_ready    (i_ready),
        .i_out_value    (o_out_value),
        .i_out_col      (o_out_col),
        .i_out_row      (o_out_row),
        .i_edge_count   (o_edge_count),
        .i_last_of_item (o_last_of_item),
        .i_frame_done   (o_frame_done),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_sobel_edge_threshold failed");
            $finish;
        end
    end

    // result side: random stall after each word, with stall-free stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_stall = 0;
            i_ready <= 1'b0;
        end else if (o_valid && i_ready) begin
            if ($urandom_range(0, 19) == 0) begin
                rx_burst = !rx_burst;
            end
            rx_stall = rx_burst ? 0 : $urandom_range(0, 6);
            i_ready <= (rx_stall == 0);
        end else if (rx_stall > 0) begin
            rx_stall--;
            i_ready <= (rx_stall == 0);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // pixel source patterns
    function automatic logic [PIX_W-1:0] next_pixel(input t_pix_mode mode, input int idx);
        case (mode)
            PIX_RAMP: begin
                // dark left, bright right: clamped horizontal gradient
                return (idx % 3 == 0) ? 8'd0 : ((idx % 3 == 1) ? 8'd128 : 8'd255);
            end
            PIX_CHECKER: begin
                return (((idx + idx / 4) % 2) == 1) ? 8'hFF : 8'h00;
            end
            default: begin
                case ($urandom_range(0, 3))
                    0:       return PIX_W'($urandom_range(0, 255));
                    1:       return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
                    default: return PIX_W'($urandom_range(96, 160));
                endcase
            end
        endcase
        return '0;
    endfunction

    // one pixel word with a random lead-in gap
    task automatic push_pixel(input logic [PIX_W-1:0] px);
        int gap;
        if ($urandom_range(0, 19) == 0) begin
            tx_burst = !tx_burst;
        end
        gap = tx_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_pixel <= px;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // program the registers, stream pixels, then drain
    task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                             input logic [CFG_W-1:0] thr, input int count,
                             input t_pix_mode mode, input bit spare);
        int n;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IMAGE_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_IMAGE_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_EDGE_THRESHOLD;
        i_cfg_data <= thr;
        @(posedge i_clk);
        if (spare) begin
            i_cfg_idx  <= CFG_SPARE;
            i_cfg_data <= '1;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        for (n = 0; n < count; n++) begin
            push_pixel(next_pixel(mode, n));
        end
        i_valid <= 1'b0;
        // rows with no output may still be in flight after the last word
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        i_clk      = 1'b0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_valid    = 1'b0;
        i_pixel    = '0;
        i_ready    = 1'b0;
        cycle_cnt  = 0;
        rx_stall   = 0;
        rx_burst   = 1'b0;
        tx_burst   = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: clamped gradient with zero threshold, then all zeroed
        run_phase(11'd3, 11'd3, 11'd0, 9, PIX_RAMP, 1'b1);
        run_phase(11'd4, 11'd3, 11'd256, 12, PIX_CHECKER, 1'b0);

        // sizes below the minimum, threshold at full scale
        run_phase(11'd0, 11'd2, 11'd255, 9, PIX_MIXED, 1'b0);

        // widest and tallest frames, width above the limit; the column or row
        // reached lies outside the next size, so each next phase restarts
        run_phase(11'h7FF, 11'd1, 11'd120, 6, PIX_MIXED, 1'b0);
        run_phase(11'd3, 11'd1024, 11'd60, 18, PIX_MIXED, 1'b0);

        // width shrink past the column restarts the frame
        run_phase(11'd6, 11'd4, 11'($urandom_range(0, 300)), 11, PIX_MIXED, 1'b0);
        run_phase(11'd4, 11'd4, 11'($urandom_range(0, 300)), 16, PIX_MIXED, 1'b0);

        // height shrink past the row restarts the frame, threshold masked
        run_phase(11'd3, 11'd6, 11'($urandom_range(0, 300)), 13, PIX_MIXED, 1'b0);
        run_phase(11'd3, 11'd4, 11'h7FF, 12, PIX_MIXED, 1'b0);

        // height grown mid-frame keeps going
        run_phase(11'd4, 11'd3, 11'($urandom_range(0, 300)), 6, PIX_MIXED, 1'b0);
        run_phase(11'd4, 11'd4, 11'($urandom_range(0, 300)), 10, PIX_MIXED, 1'b0);

        // width shrunk mid-frame, still beyond the column: no restart
        run_phase(11'd5, 11'd3, 11'($urandom_range(0, 300)), 7, PIX_MIXED, 1'b0);
        run_phase(11'd4, 11'd3, 11'($urandom_range(0, 300)), 6, PIX_MIXED, 1'b0);

        // random small frames
        for (k = 0; k < 2; k++) begin
            fw = $urandom_range(3, 5);
            fh = $urandom_range(3, 4);
            run_phase(11'(fw), 11'(fh), 11'($urandom_range(0, 300)), fw * fh,
                      PIX_MIXED, 1'b0);
        end

        @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb_sobel_edge_threshold passed");
        end else begin
            $display("tb_sobel_edge_threshold failed");
        end
        $finish;
    end

endmodule
